[rtl/core/lpcf_pkg.sv]
// Shared constants, codes and handshake structs of the crossfade flasher.
package lpcf_pkg;

  localparam int unsigned CH_BITS  = 8;
  localparam int unsigned COLOR_W  = 3 * CH_BITS;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned HC_W     = 8;
  localparam int unsigned NUM_W    = STEP_W + CH_BITS;
  localparam int unsigned DCNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = COLOR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDLESS     = 3'd4;

  localparam logic [COLOR_W-1:0] START_COLOR_RST = '0;
  localparam logic [COLOR_W-1:0] END_COLOR_RST   = '1;
  localparam logic [STEP_W-1:0]  FADE_STEPS_RST  = 8'd50;
  localparam logic [LIMIT_W-1:0] FLASH_LIMIT_RST = 7'd3;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic [STEP_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/lpcf_if.sv]
// Handshake interfaces for the tick, result and configuration channels.
interface lpcf_tick_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lpcf_res_if import lpcf_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] red;
  logic [CH_BITS-1:0] green;
  logic [CH_BITS-1:0] blue;
  logic               done_res;
  modport source (output valid, output red, output green, output blue, output done_res,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input done_res,
                output ready);
endinterface

interface lpcf_cfg_if import lpcf_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/led_pingpong_crossfade_flasher_unit.sv]
// Ping-pong RGB crossfade flasher: sequencer around one shared divider.
//
// Channels: tick_i carries one animation tick with a restart bit; res_o returns
// one result per tick (red, green, blue, done_res); cfg_i writes the registers
// start_color (0), end_color (1), fade_steps (2), flash_limit (3), endless (4).
// Configuration is taken at any time and must only be written while idle.
//
// Sequence: each tick runs one phase reduction on the divider and then one
// division per colour channel, each producing NUM_W quotient bits, with
// sequencing states between them; the next tick is taken once the result has
// reached the output register. With fade_steps of one or zero the three
// divisions are skipped.
// Reset clears phase, half-cycle count and the done flag and loads the
// register defaults. While res_o is stalled the finished result holds in the
// output register; a new tick is still accepted and computed, and it waits
// before loading until the earlier result has been taken.
module led_pingpong_crossfade_flasher_unit import lpcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lpcf_tick_if.sink  tick_i,
  lpcf_cfg_if.sink   cfg_i,
  lpcf_res_if.source res_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MOD_GO   = 3'd1;
  localparam logic [2:0] ST_MOD_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL      = 3'd3;
  localparam logic [2:0] ST_DIV_GO   = 3'd4;
  localparam logic [2:0] ST_DIV_WAIT = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  // configuration registers
  logic [COLOR_W-1:0] start_q;
  logic [COLOR_W-1:0] end_q;
  logic [STEP_W-1:0]  fsteps_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               endless_q;

  // run state
  logic [2:0]         state_q, state_d;
  logic [STEP_W-1:0]  phase_q, phase_d;
  logic [HC_W-1:0]    hc_q, hc_d;
  logic               fin_q, fin_d;
  logic               restart_q, restart_d;
  logic [1:0]         chan_q, chan_d;

  // per-tick working values
  logic [STEP_W-1:0]  pos_q, pos_d;
  logic [STEP_W-1:0]  span_q, span_d;
  logic [NUM_W-1:0]   prod_q, prod_d;
  logic               neg_q, neg_d;
  logic [CH_BITS-1:0] chres_q [3];
  logic               chres_we;
  logic [CH_BITS-1:0] chres_val;

  logic               out_valid_q, out_valid_d;
  logic [CH_BITS-1:0] red_q, green_q, blue_q;
  logic               done_q;
  logic               out_load;

  logic [STEP_W-1:0]  steps;
  logic [STEP_W-1:0]  p;
  logic [HC_W-1:0]    hc_new;
  logic [CH_BITS-1:0] s_ch, e_ch, mag;
  logic               accept;
  logic [NUM_W-1:0]   q_adj;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lpcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign steps  = (fsteps_q == '0) ? STEP_W'(1) : fsteps_q;
  assign accept = tick_i.valid && tick_i.ready;
  assign tick_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  // channel under work: red first, taken from the top of the packed colour
  always_comb begin
    case (chan_q)
      2'd0: begin
        s_ch = start_q[3*CH_BITS-1:2*CH_BITS];
        e_ch = end_q[3*CH_BITS-1:2*CH_BITS];
      end
      2'd1: begin
        s_ch = start_q[2*CH_BITS-1:CH_BITS];
        e_ch = end_q[2*CH_BITS-1:CH_BITS];
      end
      default: begin
        s_ch = start_q[CH_BITS-1:0];
        e_ch = end_q[CH_BITS-1:0];
      end
    endcase
  end

  assign mag = (e_ch < s_ch) ? (s_ch - e_ch) : (e_ch - s_ch);

  // phase reduced modulo the current step count
  assign p = div_rsp.rem;
  assign hc_new = restart_q ? '0 : ((p == '0) ? hc_q + HC_W'(1) : hc_q);

  // floor division of a negative numerator rounds away from zero
  assign q_adj = div_rsp.quot + NUM_W'(neg_q && (div_rsp.rem != '0));

  always_comb begin
    div_req.start    = (state_q == ST_MOD_GO) || (state_q == ST_DIV_GO);
    div_req.dividend = (state_q == ST_MOD_GO) ? NUM_W'(phase_q) : prod_q;
    div_req.divisor  = (state_q == ST_MOD_GO) ? steps : span_q;
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    hc_d      = hc_q;
    fin_d     = fin_q;
    restart_d = restart_q;
    chan_d    = chan_q;
    pos_d     = pos_q;
    span_d    = span_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    chres_we  = 1'b0;
    chres_val = s_ch;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          restart_d = tick_i.restart;
          // clear the phase before the divider reduces it
          if (tick_i.restart) begin
            phase_d = '0;
          end
          state_d   = ST_MOD_GO;
        end
      end
      ST_MOD_GO: begin
        state_d = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          hc_d    = hc_new;
          span_d  = steps - STEP_W'(1);
          pos_d   = hc_new[0] ? (steps - STEP_W'(1) - p) : p;
          phase_d = (p + STEP_W'(1) == steps) ? '0 : p + STEP_W'(1);
          fin_d   = (restart_q ? 1'b0 : fin_q)
                    | ((hc_new >> 1) >= HC_W'(limit_q) && !endless_q);
          chan_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = NUM_W'(pos_q) * NUM_W'(mag);
        neg_d  = e_ch < s_ch;
        if (span_q == '0) begin
          chres_we  = 1'b1;
          chres_val = s_ch;
          chan_d    = chan_q + 2'd1;
          state_d   = (chan_q == 2'd2) ? ST_FIN : ST_MUL;
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          chres_we  = 1'b1;
          chres_val = neg_q ? (s_ch - q_adj[CH_BITS-1:0]) : (s_ch + q_adj[CH_BITS-1:0]);
          chan_d    = chan_q + 2'd1;
          state_d   = (chan_q == 2'd2) ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_COLOR_RST;
      end_q       <= END_COLOR_RST;
      fsteps_q    <= FADE_STEPS_RST;
      limit_q     <= FLASH_LIMIT_RST;
      endless_q   <= 1'b0;
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      hc_q        <= '0;
      fin_q       <= 1'b0;
      restart_q   <= 1'b0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_START_COLOR: start_q   <= cfg_i.data[COLOR_W-1:0];
          CFG_END_COLOR:   end_q     <= cfg_i.data[COLOR_W-1:0];
          CFG_FADE_STEPS:  fsteps_q  <= cfg_i.data[STEP_W-1:0];
          CFG_FLASH_LIMIT: limit_q   <= cfg_i.data[LIMIT_W-1:0];
          CFG_ENDLESS:     endless_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      phase_q     <= phase_d;
      hc_q        <= hc_d;
      fin_q       <= fin_d;
      restart_q   <= restart_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    span_q <= span_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    if (chres_we) begin
      chres_q[chan_q] <= chres_val;
    end
    if (out_load) begin
      red_q   <= chres_q[0];
      green_q <= chres_q[1];
      blue_q  <= chres_q[2];
      done_q  <= fin_q;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.red      = red_q;
  assign res_o.green    = green_q;
  assign res_o.blue     = blue_q;
  assign res_o.done_res = done_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_MOD_WAIT || state_q == ST_DIV_WAIT))
    else $error("divider finished outside a wait state");

  a_one_tick_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !tick_i.ready)
    else $error("second item taken while a tick is in work");

  a_done_clears_on_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fin_q) |-> $past(restart_q))
    else $error("done flag dropped without a restart");

endmodule

[rtl/core/lpcf_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module lpcf_div import lpcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [NUM_W-1:0]  dvd_q, dvd_d;
  logic [STEP_W-1:0] dsr_q, dsr_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = DCNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      dvd_d = {dvd_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule
